// ===== rtl/core/button_gesture_classifier_top_macros.svh =====
// ----------------------------------------------------------------------------
// Button gesture classifier assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BGC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgc assertion failed");

// Next-cycle implication.
`define BGC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgc assertion failed");

`else

`define BGC_ASSERT_NOW(label, ante, cons)
`define BGC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/bgc_pkg.sv =====
// ----------------------------------------------------------------------------
// Button gesture classifier package
// Shared types, state codes, command codes and register map.
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam int TimeW  = 32;
    localparam int LimitW = 16;
    localparam int CmdW   = 2;
    localparam int StateW = 2;
    localparam int AddrW  = 4;
    localparam int DataW  = 32;

    // Gesture states.
    localparam logic [StateW-1:0] ST_IDLE  = 2'd0;
    localparam logic [StateW-1:0] ST_DOWN1 = 2'd1;
    localparam logic [StateW-1:0] ST_WAIT  = 2'd2;
    localparam logic [StateW-1:0] ST_DOWN2 = 2'd3;

    // Command codes.
    localparam logic [CmdW-1:0] CMD_PAUSE  = 2'd0;
    localparam logic [CmdW-1:0] CMD_RESUME = 2'd1;
    localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CmdW-1:0] CMD_SKIP   = 2'd3;

    // Register indexes (word address bits [3:2]).
    localparam logic [1:0] REG_SHORT_CLICK = 2'd0;
    localparam logic [1:0] REG_HOLD        = 2'd1;
    localparam logic [1:0] REG_DBL_GAP     = 2'd2;

    localparam logic [LimitW-1:0] SHORT_CLICK_RESET = 16'd200;
    localparam logic [LimitW-1:0] HOLD_RESET        = 16'd1000;
    localparam logic [LimitW-1:0] DBL_GAP_RESET     = 16'd300;

    typedef struct packed {
        logic [LimitW-1:0] short_click_limit;
        logic [LimitW-1:0] hold_limit;
        logic [LimitW-1:0] double_click_gap;
    } cfg_t;

    typedef struct packed {
        logic             press_seen;
        logic             release_seen;
        logic [TimeW-1:0] press_time;
        logic [TimeW-1:0] release_time;
        logic [TimeW-1:0] now_time;
        logic             is_playing;
    } poll_t;

endpackage

// ===== rtl/core/button_gesture_classifier_top.sv =====
// ----------------------------------------------------------------------------
// Button gesture classifier top level
// Classifies button polls into pause, resume, skip and clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   Poll channel: poll_valid with the six poll fields; a transaction is taken
//   at a rising edge with poll_valid high and poll_stall low.
//   Command channel: cmd_valid with command; a transaction completes at a
//   rising edge with cmd_valid high and cmd_stall low. A poll yields zero or
//   one command transaction.
//   A taken poll passes through the input register and then the result
//   register, which presents its command on cmd_valid. Throughput is one
//   poll per cycle while the receiver does not stall; the rate is set by the
//   input register and the result register, with the gesture state updated
//   as a poll moves from the one to the other.
//   When the receiver stalls, the command register holds its value and the
//   input register can still take one more poll; poll_stall rises only when
//   both registers are occupied and the downstream side stalls.
//   Reset (rst_n low, asynchronous) returns the gesture state to idle, empties
//   both registers and loads the default limits (200, 1000, 300 ticks).
//   The APB-style port at byte addresses 0, 4 and 8 holds the short click
//   limit, hold limit and double click gap; write it only while idle.
// ----------------------------------------------------------------------------
`include "button_gesture_classifier_top_macros.svh"

module button_gesture_classifier_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // Poll channel
    input  logic                        poll_valid,
    output logic                        poll_stall,
    input  logic                        press_seen,
    input  logic                        release_seen,
    input  logic [bgc_pkg::TimeW-1:0]   press_time,
    input  logic [bgc_pkg::TimeW-1:0]   release_time,
    input  logic [bgc_pkg::TimeW-1:0]   now_time,
    input  logic                        is_playing,
    // Command channel
    output logic                        cmd_valid,
    input  logic                        cmd_stall,
    output logic [bgc_pkg::CmdW-1:0]    command,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bgc_pkg::AddrW-1:0]   paddr,
    input  logic [bgc_pkg::DataW-1:0]   pwdata,
    output logic [bgc_pkg::DataW-1:0]   prdata,
    output logic                        pready
);
    import bgc_pkg::*;

    cfg_t            cfg;
    poll_t           poll_reg;
    poll_t           poll_next;
    logic            in_vld_reg;
    logic            in_vld_next;
    logic            cmd_vld_reg;
    logic            cmd_vld_next;
    logic [CmdW-1:0] cmd_reg;
    logic [CmdW-1:0] cmd_next;
    logic            poll_take;
    logic            advance;
    logic            emit;
    logic [CmdW-1:0] cmd;

    // The held poll moves on whenever the command register is free or drains.
    assign advance    = in_vld_reg && (!cmd_vld_reg || !cmd_stall);
    assign poll_stall = in_vld_reg && !advance;
    assign poll_take  = poll_valid && !poll_stall;

    assign cmd_valid = cmd_vld_reg;
    assign command   = cmd_reg;

    bgc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bgc_classify u_classify (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .poll  (poll_reg),
        .cfg   (cfg),
        .emit  (emit),
        .cmd   (cmd)
    );

    // Input register: loads a new poll transaction whenever one is taken.
    always_comb
    begin
        poll_next   = poll_reg;
        in_vld_next = in_vld_reg;
        if (poll_take)
        begin
            poll_next.press_seen   = press_seen;
            poll_next.release_seen = release_seen;
            poll_next.press_time   = press_time;
            poll_next.release_time = release_time;
            poll_next.now_time     = now_time;
            poll_next.is_playing   = is_playing;
            in_vld_next            = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    // Result register: holds a command until the receiver takes it.
    always_comb
    begin
        cmd_next     = cmd_reg;
        cmd_vld_next = cmd_vld_reg;
        if (advance && emit)
        begin
            cmd_next     = cmd;
            cmd_vld_next = 1'b1;
        end
        else if (cmd_vld_reg && !cmd_stall)
        begin
            cmd_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            cmd_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            cmd_vld_reg <= cmd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        poll_reg <= poll_next;
        cmd_reg  <= cmd_next;
    end

    // Back-pressure reaches the poll side only with both registers full.
    `BGC_ASSERT_NOW(a_stall_cause, poll_stall, in_vld_reg && cmd_vld_reg && cmd_stall)
    // A fresh command always comes from a poll that was held in the input register.
    `BGC_ASSERT_NOW(a_cmd_source, $rose(cmd_vld_reg), $past(in_vld_reg))

endmodule

// ===== rtl/core/bgc_regs.sv =====
// ----------------------------------------------------------------------------
// Button gesture classifier configuration registers
// APB-style register file holding the three timing limits.
// ----------------------------------------------------------------------------
module bgc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bgc_pkg::AddrW-1:0]   paddr,
    input  logic [bgc_pkg::DataW-1:0]   pwdata,
    output logic [bgc_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    output bgc_pkg::cfg_t               cfg
);
    import bgc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SHORT_CLICK: cfg_next.short_click_limit = pwdata[LimitW-1:0];
                REG_HOLD:        cfg_next.hold_limit        = pwdata[LimitW-1:0];
                REG_DBL_GAP:     cfg_next.double_click_gap  = pwdata[LimitW-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SHORT_CLICK: prdata = {{(DataW-LimitW){1'b0}}, cfg_reg.short_click_limit};
            REG_HOLD:        prdata = {{(DataW-LimitW){1'b0}}, cfg_reg.hold_limit};
            REG_DBL_GAP:     prdata = {{(DataW-LimitW){1'b0}}, cfg_reg.double_click_gap};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_click_limit <= SHORT_CLICK_RESET;
            cfg_reg.hold_limit        <= HOLD_RESET;
            cfg_reg.double_click_gap  <= DBL_GAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/bgc_classify.sv =====
// ----------------------------------------------------------------------------
// Button gesture classifier state machine
// Four-state gesture tracker that turns one poll into at most one command.
// ----------------------------------------------------------------------------
`include "button_gesture_classifier_top_macros.svh"

module bgc_classify (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  bgc_pkg::poll_t            poll,
    input  bgc_pkg::cfg_t             cfg,
    output logic                      emit,
    output logic [bgc_pkg::CmdW-1:0]  cmd
);
    import bgc_pkg::*;

    logic [StateW-1:0] state_reg;
    logic [StateW-1:0] state_next;
    logic [StateW-1:0] state_upd;
    logic [TimeW-1:0]  rel_minus_press;
    logic [TimeW-1:0]  press_minus_rel;
    logic [TimeW-1:0]  now_minus_press;
    logic [TimeW-1:0]  now_minus_rel;
    logic [TimeW-1:0]  short_lim;
    logic [TimeW-1:0]  hold_lim;
    logic [TimeW-1:0]  gap_lim;
    logic [CmdW-1:0]   single_cmd;

    // All differences wrap modulo 2^32.
    assign rel_minus_press = poll.release_time - poll.press_time;
    assign press_minus_rel = poll.press_time - poll.release_time;
    assign now_minus_press = poll.now_time - poll.press_time;
    assign now_minus_rel   = poll.now_time - poll.release_time;

    assign short_lim = {{(TimeW-LimitW){1'b0}}, cfg.short_click_limit};
    assign hold_lim  = {{(TimeW-LimitW){1'b0}}, cfg.hold_limit};
    assign gap_lim   = {{(TimeW-LimitW){1'b0}}, cfg.double_click_gap};

    assign single_cmd = poll.is_playing ? CMD_PAUSE : CMD_RESUME;

    always_comb
    begin
        state_upd = state_reg;
        emit      = 1'b0;
        cmd       = CMD_PAUSE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (poll.press_seen)
                begin
                    state_upd = ST_DOWN1;
                end
            end
            ST_DOWN1:
            begin
                if (poll.release_seen)
                begin
                    if (rel_minus_press > short_lim)
                    begin
                        state_upd = ST_IDLE;
                        emit      = 1'b1;
                        cmd       = single_cmd;
                    end
                    else
                    begin
                        state_upd = ST_WAIT;
                    end
                end
                else if (now_minus_press >= hold_lim)
                begin
                    state_upd = ST_IDLE;
                    emit      = 1'b1;
                    cmd       = CMD_CLEAR;
                end
            end
            ST_WAIT:
            begin
                if (poll.press_seen)
                begin
                    if (press_minus_rel > gap_lim)
                    begin
                        state_upd = ST_IDLE;
                        emit      = 1'b1;
                        cmd       = single_cmd;
                    end
                    else
                    begin
                        state_upd = ST_DOWN2;
                    end
                end
                else if (now_minus_rel > gap_lim)
                begin
                    state_upd = ST_IDLE;
                    emit      = 1'b1;
                    cmd       = single_cmd;
                end
            end
            ST_DOWN2:
            begin
                if (poll.release_seen)
                begin
                    state_upd = ST_IDLE;
                    emit      = 1'b1;
                    cmd       = (rel_minus_press <= short_lim) ? CMD_SKIP : single_cmd;
                end
            end
            default:
            begin
                state_upd = ST_IDLE;
            end
        endcase
    end

    assign state_next = step ? state_upd : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Idle never produces a command.
    `BGC_ASSERT_NOW(a_idle_silent, state_reg == ST_IDLE, !emit)
    // Every emitted command ends the gesture.
    `BGC_ASSERT_NEXT(a_emit_to_idle, step && emit, state_reg == ST_IDLE)
    // Skip only comes out of the second press.
    `BGC_ASSERT_NOW(a_skip_from_down2, emit && cmd == CMD_SKIP, state_reg == ST_DOWN2)

endmodule
